// ===== sv/tasm_pkg.sv =====
// Shared types, constants and helpers for the three-axis stage motion model.
package tasm_pkg;

  localparam int NUM_AXES = 3;
  localparam int AX_W = 2;
  localparam int POS_W = 32;
  localparam int MD_A_W = 33;
  localparam int MD_P_W = 65;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 65;
  localparam int MD_CNT_W = 7;
  localparam logic [31:0] MS_PER_S = 32'd1000;

  typedef enum logic [2:0] {
    K_TICK  = 3'd0,
    K_PMOVE = 3'd1,
    K_SMOVE = 3'd2,
    K_STOP  = 3'd3,
    K_RESET = 3'd4,
    K_QUERY = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         axis;
    logic signed [31:0] target_pos;
    logic signed [31:0] move_speed;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] position;
    logic               moving;
    logic               speed_mode;
  } rsp_t;

  // Request to the shared multiply-divide unit: q = a * b / c.
  typedef struct packed {
    logic              go;
    logic [MD_A_W-1:0] a;
    logic [31:0]       b;
    logic [31:0]       c;
  } md_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_EVOLVE,
    S_EV_WAIT,
    S_POST,
    S_MOVE,
    S_MV_WAIT,
    S_REPORT,
    S_REJECT
  } seq_state_t;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [MD_P_W:0] v);
    logic signed [MD_P_W:0] hi;
    logic signed [MD_P_W:0] lo;
    hi = (MD_P_W + 1)'(32'sh7FFFFFFF);
    lo = -(MD_P_W + 1)'(33'sh080000000);
    if (v > hi) return 32'h7FFFFFFF;
    else if (v < lo) return 32'h80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== sv/tasm_muldiv.sv =====
// Bit-serial multiply then restoring divide: q = a * b / c, truncated.
module tasm_muldiv (
  input  logic                      clk,
  input  logic                      rst,
  input  tasm_pkg::md_req_t         req,
  output logic                      done,
  output logic [tasm_pkg::MD_P_W-1:0] q
);

  tasm_pkg::md_phase_t phase;
  logic [tasm_pkg::MD_P_W-1:0]   acc;
  logic [tasm_pkg::MD_A_W-1:0]   a_reg;
  logic [31:0]                   b_reg;
  logic [31:0]                   c_reg;
  logic [31:0]                   rem;
  logic [tasm_pkg::MD_CNT_W-1:0] cnt;
  logic [32:0]                   trial;
  logic                          fits;

  // One divide digit: shift in the next dividend bit and try subtract
  assign trial = {rem, acc[tasm_pkg::MD_P_W-1]};
  assign fits  = trial >= {1'b0, c_reg};

  // Sequence multiply steps, then divide steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tasm_pkg::MD_IDLE;
      cnt   <= '0;
    end else begin
      unique case (phase)
        tasm_pkg::MD_IDLE: begin
          if (req.go) begin
            a_reg <= req.a;
            b_reg <= req.b;
            c_reg <= req.c;
            acc   <= '0;
            cnt   <= '0;
            phase <= tasm_pkg::MD_MUL;
          end
        end
        tasm_pkg::MD_MUL: begin
          acc   <= {acc[tasm_pkg::MD_P_W-2:0], 1'b0} +
                   (b_reg[31] ? {{(tasm_pkg::MD_P_W-tasm_pkg::MD_A_W){1'b0}}, a_reg}
                              : {tasm_pkg::MD_P_W{1'b0}});
          b_reg <= {b_reg[30:0], 1'b0};
          if (cnt == tasm_pkg::MD_CNT_W'(tasm_pkg::MUL_STEPS - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            phase <= tasm_pkg::MD_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tasm_pkg::MD_DIV: begin
          rem <= fits ? 32'(trial - {1'b0, c_reg}) : trial[31:0];
          acc <= {acc[tasm_pkg::MD_P_W-2:0], fits};
          if (cnt == tasm_pkg::MD_CNT_W'(tasm_pkg::DIV_STEPS - 1)) begin
            phase <= tasm_pkg::MD_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tasm_pkg::MD_DONE: begin
          phase <= tasm_pkg::MD_IDLE;
        end
        default: phase <= tasm_pkg::MD_IDLE;
      endcase
    end
  end

  assign done = (phase == tasm_pkg::MD_DONE);
  assign q    = acc;

endmodule

// ===== sv/three_axis_stage_motion_model_top.sv =====
// Three-axis stage motion model: command sequencer, axis records and result beat.
// A rejected command or a reset of an idle axis goes from decode straight to the result;
// a tick, query or stop with no divide passes evolve and post first; a position move makes
// up to two passes through the bit-serial muldiv unit, 32 multiply plus 65 divide steps each.
// One item at a time: busy drops as the result beat shows on done for exactly one cycle,
// so the next command is taken at the edge that ends the beat; the receiver cannot stall.
// Synchronous reset clears time, all axis records and the sequencer.
module three_axis_stage_motion_model_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tasm_pkg::cmd_t cmd,
  output logic           done,
  output tasm_pkg::rsp_t rsp
);

  tasm_pkg::seq_state_t state;
  tasm_pkg::seq_state_t state_next;

  logic [31:0] now_ms;
  logic [31:0] cur_pos    [tasm_pkg::NUM_AXES];
  logic        active     [tasm_pkg::NUM_AXES];
  logic        is_speed   [tasm_pkg::NUM_AXES];
  logic [31:0] start_pos  [tasm_pkg::NUM_AXES];
  logic [31:0] start_time [tasm_pkg::NUM_AXES];
  logic [31:0] goal_pos   [tasm_pkg::NUM_AXES];
  logic [31:0] rate       [tasm_pkg::NUM_AXES];
  logic [31:0] end_time   [tasm_pkg::NUM_AXES];

  logic [2:0]  kind;
  logic [tasm_pkg::AX_W-1:0] ax;
  logic [31:0] tgt;
  logic [31:0] spd;
  logic        neg;

  logic        ok;
  logic [31:0] el;
  logic [31:0] dur;
  logic [32:0] pdiff;
  logic [32:0] pmag;
  logic [31:0] rmag;
  logic [31:0] smag;
  logic        md_done;
  logic [tasm_pkg::MD_P_W-1:0] md_q;
  logic signed [tasm_pkg::MD_P_W:0] ev_sum;
  logic [31:0] dsat;
  tasm_pkg::md_req_t md_req;

  // Decode the held command against the addressed axis record
  assign ok    = (32'(ax) < tasm_pkg::NUM_AXES);
  assign el    = now_ms - start_time[ax];
  assign dur   = end_time[ax] - start_time[ax];
  assign pdiff = {goal_pos[ax][31], goal_pos[ax]} - {start_pos[ax][31], start_pos[ax]};
  assign pmag  = pdiff[32] ? (33'd0 - pdiff) : pdiff;
  assign rmag  = rate[ax][31] ? (32'd0 - rate[ax]) : rate[ax];
  assign smag  = spd[31] ? (32'd0 - spd) : spd;
  assign ev_sum = $signed({{(tasm_pkg::MD_P_W-31){start_pos[ax][31]}}, start_pos[ax]}) +
                  (neg ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q}));
  assign dsat  = (|md_q[tasm_pkg::MD_P_W-1:32]) ? 32'hFFFFFFFF : md_q[31:0];

  tasm_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .q    (md_q)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= tasm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Pick the next step and drive the multiply-divide request
  always_comb begin
    state_next = state;
    md_req     = '0;
    unique case (state)
      tasm_pkg::S_IDLE: begin
        if (start) state_next = tasm_pkg::S_CMD;
      end
      tasm_pkg::S_CMD: begin
        if (!ok) begin
          state_next = tasm_pkg::S_REJECT;
        end else begin
          unique case (kind)
            tasm_pkg::K_TICK, tasm_pkg::K_QUERY, tasm_pkg::K_SMOVE, tasm_pkg::K_STOP:
              state_next = tasm_pkg::S_EVOLVE;
            tasm_pkg::K_PMOVE:
              state_next = (spd == 32'd0) ? tasm_pkg::S_REJECT : tasm_pkg::S_EVOLVE;
            tasm_pkg::K_RESET:
              state_next = (active[ax] && !is_speed[ax]) ? tasm_pkg::S_MOVE
                                                         : tasm_pkg::S_REPORT;
            default: state_next = tasm_pkg::S_REJECT;
          endcase
        end
      end
      tasm_pkg::S_EVOLVE: begin
        if (!active[ax]) begin
          state_next = tasm_pkg::S_POST;
        end else if (is_speed[ax]) begin
          md_req     = '{go: 1'b1, a: {1'b0, rmag}, b: el, c: tasm_pkg::MS_PER_S};
          state_next = tasm_pkg::S_EV_WAIT;
        end else if (el >= dur) begin
          state_next = tasm_pkg::S_POST;
        end else begin
          md_req     = '{go: 1'b1, a: pmag, b: el, c: dur};
          state_next = tasm_pkg::S_EV_WAIT;
        end
      end
      tasm_pkg::S_EV_WAIT: begin
        if (md_done) state_next = tasm_pkg::S_POST;
      end
      tasm_pkg::S_POST: begin
        state_next = (kind == tasm_pkg::K_PMOVE) ? tasm_pkg::S_MOVE : tasm_pkg::S_REPORT;
      end
      tasm_pkg::S_MOVE: begin
        md_req     = '{go: 1'b1, a: pmag, b: tasm_pkg::MS_PER_S, c: rate[ax]};
        state_next = tasm_pkg::S_MV_WAIT;
      end
      tasm_pkg::S_MV_WAIT: begin
        if (md_done) state_next = tasm_pkg::S_REPORT;
      end
      tasm_pkg::S_REPORT, tasm_pkg::S_REJECT: begin
        state_next = tasm_pkg::S_IDLE;
      end
      default: state_next = tasm_pkg::S_IDLE;
    endcase
  end

  // Update time, axis records and the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      done   <= 1'b0;
      for (int i = 0; i < tasm_pkg::NUM_AXES; i++) begin
        cur_pos[i]    <= '0;
        active[i]     <= 1'b0;
        is_speed[i]   <= 1'b0;
        start_pos[i]  <= '0;
        start_time[i] <= '0;
        goal_pos[i]   <= '0;
        rate[i]       <= '0;
        end_time[i]   <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        tasm_pkg::S_IDLE: begin
          if (start) begin
            kind <= cmd.kind;
            ax   <= cmd.axis;
            tgt  <= cmd.target_pos;
            spd  <= cmd.move_speed;
            if (cmd.kind == tasm_pkg::K_TICK) now_ms <= now_ms + 32'd1;
          end
        end
        tasm_pkg::S_CMD: begin
          // Reset zeroes the axis and restarts an active move from zero
          if (ok && kind == tasm_pkg::K_RESET) begin
            cur_pos[ax] <= '0;
            if (active[ax]) begin
              start_pos[ax]  <= '0;
              start_time[ax] <= now_ms;
              if (is_speed[ax]) begin
                goal_pos[ax] <= '0;
                end_time[ax] <= now_ms;
              end
            end
          end
        end
        tasm_pkg::S_EVOLVE: begin
          if (active[ax]) begin
            if (is_speed[ax]) neg <= rate[ax][31];
            else if (el >= dur) cur_pos[ax] <= goal_pos[ax];
            else neg <= pdiff[32];
          end
        end
        tasm_pkg::S_EV_WAIT: begin
          if (md_done) cur_pos[ax] <= tasm_pkg::sat32(ev_sum);
        end
        tasm_pkg::S_POST: begin
          unique case (kind)
            tasm_pkg::K_PMOVE: begin
              active[ax]     <= 1'b1;
              is_speed[ax]   <= 1'b0;
              start_pos[ax]  <= cur_pos[ax];
              start_time[ax] <= now_ms;
              goal_pos[ax]   <= tgt;
              rate[ax]       <= smag;
            end
            tasm_pkg::K_SMOVE: begin
              active[ax]     <= 1'b1;
              is_speed[ax]   <= 1'b1;
              start_pos[ax]  <= cur_pos[ax];
              start_time[ax] <= now_ms;
              goal_pos[ax]   <= cur_pos[ax];
              rate[ax]       <= spd;
              end_time[ax]   <= now_ms;
            end
            tasm_pkg::K_STOP: active[ax] <= 1'b0;
            default: ;
          endcase
        end
        tasm_pkg::S_MV_WAIT: begin
          if (md_done) end_time[ax] <= start_time[ax] + dsat;
        end
        tasm_pkg::S_REPORT: begin
          done           <= 1'b1;
          rsp.accepted   <= 1'b1;
          rsp.position   <= cur_pos[ax];
          rsp.moving     <= active[ax];
          rsp.speed_mode <= active[ax] && is_speed[ax];
        end
        tasm_pkg::S_REJECT: begin
          done <= 1'b1;
          rsp  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != tasm_pkg::S_IDLE);

endmodule
